// ===== rtl/core/plf_pkg.sv =====
// Shared types and constants for the Playfair digraph cipher unit.
// No dependencies; imported by every module under rtl/core.
`timescale 1ns / 1ps

package plf_pkg;

  // Key square geometry
  localparam int unsigned SquareDim   = 5;
  localparam int unsigned LetterW     = 5;
  localparam int unsigned IdxW        = 3;
  localparam int unsigned AsciiW      = 7;
  localparam int unsigned RowW        = SquareDim * LetterW;

  // Letter indices (A = 0)
  localparam logic [LetterW-1:0] LetterI = 5'd8;
  localparam logic [LetterW-1:0] LetterJ = 5'd9;
  localparam logic [LetterW-1:0] LetterX = 5'd23;

  // ASCII ranges
  localparam logic [7:0] AsciiUpperA = 8'd65;
  localparam logic [7:0] AsciiUpperZ = 8'd90;
  localparam logic [7:0] AsciiLowerA = 8'd97;
  localparam logic [7:0] AsciiLowerZ = 8'd122;

  // Register file
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  typedef enum logic [2:0] {
    REG_DECRYPT = 3'd0,
    REG_ROW_A   = 3'd1,
    REG_ROW_B   = 3'd2,
    REG_ROW_C   = 3'd3,
    REG_ROW_D   = 3'd4,
    REG_ROW_E   = 3'd5
  } reg_idx_t;

  // Reset square: A..Z without J, row-major
  localparam logic [RowW-1:0] RowAReset = 25'd4294688;
  localparam logic [RowW-1:0] RowBReset = 25'd10755269;
  localparam logic [RowW-1:0] RowCReset = 25'd16201099;
  localparam logic [RowW-1:0] RowDReset = 25'd21613104;
  localparam logic [RowW-1:0] RowEReset = 25'd27025109;

  // [row][column][letter bits], column 0 in the low bits of each row
  typedef logic [SquareDim-1:0][SquareDim-1:0][LetterW-1:0] square_t;

  typedef struct packed {
    logic    decrypt;
    square_t square;
  } cfg_t;

  // A pair waiting for lookup, or an end marker
  typedef struct packed {
    logic               valid;
    logic [LetterW-1:0] first;
    logic [LetterW-1:0] second;
    logic               pair_valid;
    logic               end_of_text;
  } pair_req_t;

  typedef struct packed {
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
  } loc_t;

endpackage

// ===== rtl/core/plf_cfg_regs.sv =====
// APB-style register file: decrypt mode and the five key square rows.
// Depends on plf_pkg.
`timescale 1ns / 1ps

module plf_cfg_regs
  import plf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic                              decrypt_mode;
  logic [SquareDim-1:0][RowW-1:0]    square_rows;
  logic                              wr_en;
  reg_idx_t                          reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[AddrW-1:2]);

  // Register writes; addresses past the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      decrypt_mode   <= 1'b0;
      square_rows[0] <= RowAReset;
      square_rows[1] <= RowBReset;
      square_rows[2] <= RowCReset;
      square_rows[3] <= RowDReset;
      square_rows[4] <= RowEReset;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DECRYPT: decrypt_mode   <= pwdata[0];
        REG_ROW_A:   square_rows[0] <= pwdata[RowW-1:0];
        REG_ROW_B:   square_rows[1] <= pwdata[RowW-1:0];
        REG_ROW_C:   square_rows[2] <= pwdata[RowW-1:0];
        REG_ROW_D:   square_rows[3] <= pwdata[RowW-1:0];
        REG_ROW_E:   square_rows[4] <= pwdata[RowW-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_DECRYPT: prdata = {{(DataW-1){1'b0}}, decrypt_mode};
      REG_ROW_A:   prdata = {{(DataW-RowW){1'b0}}, square_rows[0]};
      REG_ROW_B:   prdata = {{(DataW-RowW){1'b0}}, square_rows[1]};
      REG_ROW_C:   prdata = {{(DataW-RowW){1'b0}}, square_rows[2]};
      REG_ROW_D:   prdata = {{(DataW-RowW){1'b0}}, square_rows[3]};
      REG_ROW_E:   prdata = {{(DataW-RowW){1'b0}}, square_rows[4]};
      default:     prdata = '0;
    endcase
  end

  assign cfg = {decrypt_mode, square_t'(square_rows)};

endmodule

// ===== rtl/core/plf_pairer.sv =====
// Front end: letter filter, case folding, J to I, pairing and X padding.
// Holds the odd letter and a one-deep pair register. Depends on plf_pkg.
`timescale 1ns / 1ps

module plf_pairer
  import plf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] raw_byte,
  input  logic       final_byte,
  input  logic       req_take,
  output pair_req_t  req
);

  logic               held_valid;
  logic [LetterW-1:0] held_letter;
  logic               held_valid_next;
  logic [LetterW-1:0] held_letter_next;
  pair_req_t          req_next;
  logic               is_upper;
  logic               is_lower;
  logic               is_letter;
  logic [7:0]         offset;
  logic [LetterW-1:0] idx;
  logic               accept;

  // The pair register frees up in the same cycle it is drained
  assign in_stall = req.valid && !req_take;
  assign accept   = in_valid && !in_stall;

  // Letter classification
  always_comb begin
    is_upper  = (raw_byte >= AsciiUpperA) && (raw_byte <= AsciiUpperZ);
    is_lower  = (raw_byte >= AsciiLowerA) && (raw_byte <= AsciiLowerZ);
    is_letter = is_upper || is_lower;
    offset    = is_upper ? (raw_byte - AsciiUpperA) : (raw_byte - AsciiLowerA);
    idx       = offset[LetterW-1:0];
    if (idx == LetterJ) begin
      idx = LetterI;
    end
  end

  // Pairing decision for the incoming beat
  always_comb begin
    held_valid_next  = held_valid;
    held_letter_next = held_letter;
    req_next         = '0;
    if (is_letter && held_valid) begin
      req_next.valid       = 1'b1;
      req_next.first       = held_letter;
      req_next.second      = idx;
      req_next.pair_valid  = 1'b1;
      req_next.end_of_text = final_byte;
      held_valid_next      = 1'b0;
      held_letter_next     = '0;
    end else if (is_letter) begin
      if (final_byte) begin
        // lone last letter, padded with X
        req_next.valid       = 1'b1;
        req_next.first       = idx;
        req_next.second      = LetterX;
        req_next.pair_valid  = 1'b1;
        req_next.end_of_text = 1'b1;
        held_letter_next     = '0;
      end else begin
        held_valid_next  = 1'b1;
        held_letter_next = idx;
      end
    end else if (final_byte) begin
      req_next.valid       = 1'b1;
      req_next.end_of_text = 1'b1;
      if (held_valid) begin
        req_next.first      = held_letter;
        req_next.second     = LetterX;
        req_next.pair_valid = 1'b1;
      end
      held_valid_next  = 1'b0;
      held_letter_next = '0;
    end
  end

  // Held letter and pair register; payload bits need no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid  <= 1'b0;
      held_letter <= '0;
      req.valid   <= 1'b0;
    end else if (accept) begin
      held_valid  <= held_valid_next;
      held_letter <= held_letter_next;
      req.valid   <= req_next.valid;
    end else if (req_take) begin
      req.valid <= 1'b0;
    end
    if (accept && req_next.valid) begin
      req.first       <= req_next.first;
      req.second      <= req_next.second;
      req.pair_valid  <= req_next.pair_valid;
      req.end_of_text <= req_next.end_of_text;
    end
  end

  // A final byte always flushes the held letter
  assert property (@(posedge clk) disable iff (rst)
    (accept && final_byte) |=> !held_valid)
    else $error("held letter survived a final byte");

  // A final byte always yields a result
  assert property (@(posedge clk) disable iff (rst)
    (accept && final_byte) |=> (req.valid && req.end_of_text))
    else $error("final byte produced no end marker");

endmodule

// ===== rtl/core/plf_lookup.sv =====
// Key square lookup: locates both letters by parallel compares and applies
// the row, column or rectangle rule. Purely combinational. Depends on plf_pkg.
`timescale 1ns / 1ps

module plf_lookup
  import plf_pkg::*;
(
  input  cfg_t               cfg,
  input  logic [LetterW-1:0] first,
  input  logic [LetterW-1:0] second,
  output logic [AsciiW-1:0]  first_letter,
  output logic [AsciiW-1:0]  second_letter
);

  // First match in row-major order; a missing letter lands at row 0, column 0
  function automatic loc_t locate(input logic [LetterW-1:0] letter, input square_t sq);
    loc_t loc;
    logic found;
    loc   = '0;
    found = 1'b0;
    for (int r = 0; r < SquareDim; r++) begin
      for (int c = 0; c < SquareDim; c++) begin
        if (!found && (sq[r][c] == letter)) begin
          loc.row = IdxW'(r);
          loc.col = IdxW'(c);
          found   = 1'b1;
        end
      end
    end
    return loc;
  endfunction

  function automatic logic [IdxW-1:0] wrap_add(input logic [IdxW-1:0] v,
                                               input logic [IdxW-1:0] step);
    logic [IdxW:0] s;
    s = {1'b0, v} + {1'b0, step};
    if (s >= (IdxW+1)'(SquareDim)) begin
      s = s - (IdxW+1)'(SquareDim);
    end
    return s[IdxW-1:0];
  endfunction

  loc_t               loc_a;
  loc_t               loc_b;
  logic [IdxW-1:0]    step;
  logic [LetterW-1:0] out_a;
  logic [LetterW-1:0] out_b;

  assign loc_a = locate(first, cfg.square);
  assign loc_b = locate(second, cfg.square);
  // left or up is a shift by four modulo five
  assign step  = cfg.decrypt ? IdxW'(SquareDim - 1) : IdxW'(1);

  // Playfair rules
  always_comb begin
    if ((loc_a.row != loc_b.row) && (loc_a.col != loc_b.col)) begin
      out_a = cfg.square[loc_a.row][loc_b.col];
      out_b = cfg.square[loc_b.row][loc_a.col];
    end else if (loc_a.row == loc_b.row) begin
      out_a = cfg.square[loc_a.row][wrap_add(loc_a.col, step)];
      out_b = cfg.square[loc_b.row][wrap_add(loc_b.col, step)];
    end else begin
      out_a = cfg.square[wrap_add(loc_a.row, step)][loc_a.col];
      out_b = cfg.square[wrap_add(loc_b.row, step)][loc_b.col];
    end
  end

  assign first_letter  = AsciiUpperA[AsciiW-1:0] + {{(AsciiW-LetterW){1'b0}}, out_a};
  assign second_letter = AsciiUpperA[AsciiW-1:0] + {{(AsciiW-LetterW){1'b0}}, out_b};

endmodule

// ===== rtl/core/playfair_digraph_cipher_unit.sv =====
// Top level of the Playfair digraph cipher unit.
// Depends on plf_pkg, plf_cfg_regs, plf_pairer and plf_lookup.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid / in_stall, raw_byte, final_byte): one text byte
//   per beat. Non-letters are dropped, letters are paired; final_byte closes
//   the text and pads a lone letter with X.
//   Output channel (out_valid / out_stall): one beat per completed pair, the
//   one closed by a final byte marked end_of_text; a final byte with nothing to
//   pair gives an end marker with pair_valid low and zero letters.
//   Throughput: one byte per cycle while in_stall is low. The pair register
//   after the pairing logic and the result register after the square lookup
//   each hold one beat; a pair passes through them in that order.
//   The lookup is 25 parallel compares per letter and a cell select, all
//   between the pair register and the result register.
//   Stall: while out_stall is high a valid result holds, the pair register fills
//   and then in_stall rises; in_stall is never high while out_stall is low.
//   Reset (rst, synchronous): both pipeline registers empty, no held letter,
//   encrypt mode and the A..Z (no J) square. Write the APB registers only
//   while the unit is idle.

module playfair_digraph_cipher_unit
  import plf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready,
  // text in
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        raw_byte,
  input  logic              final_byte,
  // pairs out
  output logic              out_valid,
  input  logic              out_stall,
  output logic [AsciiW-1:0] first_letter,
  output logic [AsciiW-1:0] second_letter,
  output logic              pair_valid,
  output logic              end_of_text
);

  cfg_t              cfg;
  pair_req_t         req;
  logic              out_free;
  logic [AsciiW-1:0] lk_first;
  logic [AsciiW-1:0] lk_second;

  plf_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  plf_pairer u_pairer (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .raw_byte   (raw_byte),
    .final_byte (final_byte),
    .req_take   (out_free),
    .req        (req)
  );

  plf_lookup u_lookup (
    .cfg           (cfg),
    .first         (req.first),
    .second        (req.second),
    .first_letter  (lk_first),
    .second_letter (lk_second)
  );

  // Result register; it can load whenever it is empty or being drained
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && req.valid) begin
      first_letter  <= req.pair_valid ? lk_first : '0;
      second_letter <= req.pair_valid ? lk_second : '0;
      pair_valid    <= req.pair_valid;
      end_of_text   <= req.end_of_text;
    end
  end

  // Input never stalls while the output side is draining
  assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled with a free output");

  // Reset empties the result register
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // An end marker carries end_of_text and zero letters
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pair_valid) |-> (end_of_text && (first_letter == '0) &&
                                    (second_letter == '0)))
    else $error("malformed end marker");

  // Pair letters are always at or above ASCII A
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && pair_valid) |-> ((first_letter >= AsciiUpperA[AsciiW-1:0]) &&
                                   (second_letter >= AsciiUpperA[AsciiW-1:0])))
    else $error("pair letter below ASCII A");

endmodule

// ===== tb/playfair_digraph_cipher_unit_tb.sv =====
// Self-checking testbench for the Playfair digraph cipher unit.
// Depends on plf_pkg and playfair_digraph_cipher_unit; drives text bytes and
// key-square settings and checks every result beat against its own cipher.
`timescale 1ns / 1ps

module playfair_digraph_cipher_unit_tb
  import plf_pkg::*;
();

  localparam int WatchdogLimit = 2000;
  localparam int SettleCycles  = 4;
  localparam int ItemTarget    = 500;
  localparam int IdlePercent   = 25;

  // one result beat as the unit presents it
  typedef struct packed {
    logic [AsciiW-1:0] first;
    logic [AsciiW-1:0] second;
    logic              pair_valid;
    logic              end_of_text;
  } pair_beat_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [DataW-1:0]  pwdata = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        raw_byte = '0;
  logic              final_byte = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [AsciiW-1:0] first_letter;
  logic [AsciiW-1:0] second_letter;
  logic              pair_valid;
  logic              end_of_text;

  // cipher state kept alongside the unit
  logic               key_decrypt;
  square_t            key_square;
  logic [LetterW-1:0] held_idx;
  logic               held_full;
  pair_beat_t         pending_pairs[$];

  bit no_idle = 1'b0;
  int errors = 0;
  int bytes_sent = 0;
  int items_sent = 0;
  int pairs_checked = 0;
  int markers_checked = 0;
  int key_settings = 1;
  int quiet_cycles = 0;

  playfair_digraph_cipher_unit uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .raw_byte(raw_byte), .final_byte(final_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .first_letter(first_letter), .second_letter(second_letter),
    .pair_valid(pair_valid), .end_of_text(end_of_text)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- cipher

  // first matching cell in row-major order, else the top-left corner
  function automatic loc_t find_cell(input logic [LetterW-1:0] letter);
    loc_t hit;
    bit found;
    hit = '0;
    found = 1'b0;
    for (int r = 0; r < SquareDim; r++) begin
      for (int c = 0; c < SquareDim; c++) begin
        if (!found && key_square[r][c] == letter) begin
          hit.row = IdxW'(r);
          hit.col = IdxW'(c);
          found = 1'b1;
        end
      end
    end
    return hit;
  endfunction

  function automatic pair_beat_t encipher_pair(input logic [LetterW-1:0] a,
                                               input logic [LetterW-1:0] b,
                                               input logic eot);
    loc_t la, lb;
    int unsigned shift;
    logic [LetterW-1:0] oa, ob;
    pair_beat_t beat;
    shift = key_decrypt ? SquareDim - 1 : 1;
    la = find_cell(a);
    lb = find_cell(b);
    if (la.row != lb.row && la.col != lb.col) begin
      // rectangle: swap columns
      oa = key_square[la.row][lb.col];
      ob = key_square[lb.row][la.col];
    end else if (la.row == lb.row) begin
      // same row, equal letters included
      oa = key_square[la.row][(la.col + shift) % SquareDim];
      ob = key_square[lb.row][(lb.col + shift) % SquareDim];
    end else begin
      oa = key_square[(la.row + shift) % SquareDim][la.col];
      ob = key_square[(lb.row + shift) % SquareDim][lb.col];
    end
    beat.first       = AsciiW'(AsciiUpperA + 8'(oa));
    beat.second      = AsciiW'(AsciiUpperA + 8'(ob));
    beat.pair_valid  = 1'b1;
    beat.end_of_text = eot;
    return beat;
  endfunction

  // applies one accepted byte; returns 1 if the byte was a letter or a final
  function automatic bit cipher_byte(input logic [7:0] b, input logic fin);
    bit is_letter;
    logic [LetterW-1:0] idx;
    is_letter = 1'b0;
    idx = '0;
    if (b >= AsciiUpperA && b <= AsciiUpperZ) begin
      is_letter = 1'b1;
      idx = LetterW'(b - AsciiUpperA);
    end else if (b >= AsciiLowerA && b <= AsciiLowerZ) begin
      is_letter = 1'b1;
      idx = LetterW'(b - AsciiLowerA);
    end
    if (is_letter && idx == LetterJ) idx = LetterI;

    if (is_letter && held_full) begin
      pending_pairs.push_back(encipher_pair(held_idx, idx, fin));
      held_full = 1'b0;
      held_idx = '0;
      return 1'b1;
    end
    if (is_letter) begin
      held_idx = idx;
      held_full = 1'b1;
    end
    if (!fin) return is_letter;

    if (held_full) begin
      // lone letter padded with X
      pending_pairs.push_back(encipher_pair(held_idx, LetterX, 1'b1));
      held_full = 1'b0;
      held_idx = '0;
    end else begin
      pending_pairs.push_back('{first: '0, second: '0, pair_valid: 1'b0,
                                end_of_text: 1'b1});
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_byte(input logic [7:0] b, input logic fin);
    while (!no_idle && $urandom_range(99) < IdlePercent) begin
      in_valid   <= 1'b0;
      raw_byte   <= 8'($urandom);
      final_byte <= 1'($urandom);
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    raw_byte   <= b;
    final_byte <= fin;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    if (cipher_byte(b, fin)) items_sent++;
  endtask

  task automatic send_text(input string s, input bit close_text);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], close_text && i == s.len() - 1);
  endtask

  // let every expected beat arrive, then give the pipeline time to empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input reg_idx_t r,
                            input logic [DataW-1:0] wdata,
                            output logic [DataW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= AddrW'(4 * r);
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // write a register, mirror it, and read it back
  task automatic write_reg(input reg_idx_t r, input logic [DataW-1:0] v);
    logic [DataW-1:0] rd, mask;
    apb_access(1'b1, r, v, rd);
    if (r == REG_DECRYPT) begin
      key_decrypt = v[0];
      mask = 32'h1;
    end else begin
      key_square[r - REG_ROW_A] = v[RowW-1:0];
      mask = {{(DataW-RowW){1'b0}}, {RowW{1'b1}}};
    end
    apb_access(1'b0, r, '0, rd);
    if ((rd & mask) !== (v & mask)) begin
      errors++;
      $display("%0t: register %s read back: expected %h, actual %h",
               $time, r.name(), v & mask, rd & mask);
    end
  endtask

  task automatic load_square(input square_t sq, input bit every_row);
    for (int i = 0; i < SquareDim; i++)
      if (every_row || $urandom_range(1))
        write_reg(reg_idx_t'(REG_ROW_A + i), DataW'(sq[i]));
    key_settings++;
  endtask

  task automatic shuffled_square(output square_t sq);
    logic [LetterW-1:0] pool[SquareDim*SquareDim];
    logic [LetterW-1:0] t;
    int k, j;
    k = 0;
    for (int l = 0; l < 26; l++) begin
      if (l != LetterJ) begin
        pool[k] = LetterW'(l);
        k++;
      end
    end
    for (int i = SquareDim*SquareDim - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = pool[i];
      pool[i] = pool[j];
      pool[j] = t;
    end
    for (int i = 0; i < SquareDim*SquareDim; i++)
      sq[i / SquareDim][i % SquareDim] = pool[i];
  endtask

  // mostly letters, some repeats for equal pairs, some J or j, the rest any byte
  task automatic random_text(input bit close_text);
    int len, pick;
    logic [7:0] b, prev;
    len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
    prev = "A";
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (pick < 45)      b = 8'($urandom_range(AsciiUpperA, AsciiUpperZ));
      else if (pick < 68) b = 8'($urandom_range(AsciiLowerA, AsciiLowerZ));
      else if (pick < 78) b = prev;
      else if (pick < 82) b = ($urandom_range(1)) ? "J" : "j";
      else                b = 8'($urandom);
      if ((b >= AsciiUpperA && b <= AsciiUpperZ) || (b >= AsciiLowerA && b <= AsciiLowerZ))
        prev = b;
      send_byte(b, close_text && i == len - 1);
    end
  endtask

  // ---------------------------------------------------------------- tests

  // reset square in encrypt mode, no register writes beforehand
  task automatic test_reset_square();
    send_byte(8'h00, 1'b1);       // final with nothing held: end marker
    send_text("HIae", 1'b0);      // same row, lower case folded
    send_text("JIAV", 1'b0);      // J folds to I (equal pair), same column
    send_byte("Z", 1'b0);
    send_byte(8'hFF, 1'b1);       // final non-letter pads Z with X
    send_text("@[`{", 1'b0);      // just outside both letter ranges
    send_text("zQ", 1'b1);        // final letter completes a pair
    wait_idle();
  endtask

  task automatic test_decrypt_mode();
    write_reg(REG_DECRYPT, 32'd1);
    send_text("KIFAHQ", 1'b0);    // row left, column up, rectangle
    send_text("M", 1'b1);         // padding applies in decrypt too
    wait_idle();
  endtask

  // duplicates, missing letters and cell codes above Z
  task automatic test_degenerate_square();
    square_t sq;
    sq[0] = '0;
    sq[1] = {RowW{1'b1}};
    for (int c = 0; c < SquareDim; c++) sq[2][c] = LetterW'(26 + c);
    sq[3] = RowDReset;
    sq[4] = RowEReset;
    load_square(sq, 1'b1);
    write_reg(REG_DECRYPT, 32'd0);
    send_text("ABZQY", 1'b1);
    wait_idle();
    write_reg(REG_DECRYPT, 32'd1);
    send_text("BaSc", 1'b1);
    wait_idle();
  endtask

  task automatic test_random_keys();
    square_t sq;
    int mode, phase, texts;
    phase = 0;
    while (bytes_sent < ItemTarget) begin
      mode = $urandom_range(9);
      if (mode < 7) begin
        shuffled_square(sq);
      end else if (mode < 9) begin
        for (int i = 0; i < SquareDim; i++) sq[i] = RowW'($urandom);
      end else begin
        for (int i = 0; i < SquareDim; i++) sq[i] = $urandom_range(1) ? {RowW{1'b1}} : '0;
      end
      write_reg(REG_DECRYPT, DataW'($urandom_range(1)));
      load_square(sq, phase == 0);
      // one long stretch with neither side idling
      no_idle = (phase == 2);
      texts = no_idle ? 12 : $urandom_range(3, 8);
      for (int t = 0; t < texts; t++)
        random_text(t != texts - 1 || $urandom_range(9) != 0);
      wait_idle();
      no_idle = 1'b0;
      phase++;
    end
  endtask

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin : result_check
    pair_beat_t want, got;
    if (!rst && out_valid && !out_stall) begin
      got = {first_letter, second_letter, pair_valid, end_of_text};
      if (pending_pairs.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: expected nothing, actual %h",
                 $time, got);
      end else begin
        want = pending_pairs.pop_front();
        if (want.pair_valid) pairs_checked++;
        else markers_checked++;
        if (got !== want) begin
          errors++;
          $display("%0t: expected first=%0d second=%0d pair_valid=%0b end=%0b, %s%0d",
                   $time, want.first, want.second, want.pair_valid, want.end_of_text,
                   "actual first=", got.first);
          $display("%0t:   actual second=%0d pair_valid=%0b end=%0b",
                   $time, got.second, got.pair_valid, got.end_of_text);
        end
      end
    end
    out_stall <= !no_idle && ($urandom_range(99) < IdlePercent);
  end

  // no beat on either channel and no register access for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding",
               $time, WatchdogLimit, pending_pairs.size());
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    key_decrypt = 1'b0;
    key_square  = {RowEReset, RowDReset, RowCReset, RowBReset, RowAReset};
    held_idx    = '0;
    held_full   = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_square();
    test_decrypt_mode();
    test_degenerate_square();
    test_random_keys();
    wait_idle();

    $display("Covered %0d bytes (%0d letters or text ends) over %0d key squares,",
             bytes_sent, items_sent, key_settings);
    $display("both modes; %0d cipher pairs and %0d end markers compared.",
             pairs_checked, markers_checked);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/plf_pkg.sv
rtl/core/plf_cfg_regs.sv
rtl/core/plf_pairer.sv
rtl/core/plf_lookup.sv
rtl/core/playfair_digraph_cipher_unit.sv
tb/playfair_digraph_cipher_unit_tb.sv
